// ===== hw/rtl/cfws_pkg.sv =====
// ----------------------------------------------------------------------------
// cfws_pkg
// Shared types and constants for the circular FIFO with search.
// ----------------------------------------------------------------------------
package cfws_pkg;

  localparam int QUEUE_SLOTS_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int CMD_W           = 2;
  localparam int STAT_W          = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_SEARCH  = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stat_t;

  // Which kind of result the datapath loads into the output register
  typedef enum logic [2:0] {
    RES_OK,
    RES_FULL,
    RES_EMPTY,
    RES_READ,
    RES_SRCH
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ_WAIT,
    S_SRCH
  } state_t;

  typedef struct packed {
    logic load;
    logic enq_write;
    logic deq_read;
    logic srch_step;
    logic fin;
    res_t res_kind;
  } dp_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             srch_done;
  } dp_sts_t;

endpackage

// ===== hw/rtl/cfws_ram.sv =====
// ----------------------------------------------------------------------------
// cfws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/cfws_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfws_ctrl
// Sequencer for the circular FIFO: request handshake, command dispatch,
// search scan control and the output valid register.
// ----------------------------------------------------------------------------
module cfws_ctrl
  import cfws_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_ctl_t ctl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = (state_r != S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.cmd)
          CMD_ENQUEUE: begin
            if (out_free) begin
              ctl.fin       = 1'b1;
              ctl.res_kind  = sts.full ? RES_FULL : RES_OK;
              ctl.enq_write = !sts.full;
              state_nxt     = S_IDLE;
            end
          end
          CMD_DEQUEUE: begin
            if (sts.empty) begin
              if (out_free) begin
                ctl.fin      = 1'b1;
                ctl.res_kind = RES_EMPTY;
                state_nxt    = S_IDLE;
              end
            end else begin
              ctl.deq_read = 1'b1;
              state_nxt    = S_DEQ_WAIT;
            end
          end
          CMD_SEARCH: begin
            state_nxt = S_SRCH;
          end
          default: begin
            // unused command code: report ok, touch nothing
            if (out_free) begin
              ctl.fin      = 1'b1;
              ctl.res_kind = RES_OK;
              state_nxt    = S_IDLE;
            end
          end
        endcase
      end
      S_DEQ_WAIT: begin
        if (out_free) begin
          ctl.fin      = 1'b1;
          ctl.res_kind = RES_READ;
          state_nxt    = S_IDLE;
        end
      end
      S_SRCH: begin
        if (sts.srch_done) begin
          if (out_free) begin
            ctl.fin      = 1'b1;
            ctl.res_kind = RES_SRCH;
            state_nxt    = S_IDLE;
          end
        end else begin
          ctl.srch_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/cfws_dp.sv =====
// ----------------------------------------------------------------------------
// cfws_dp
// Datapath for the circular FIFO: head and tail indexes, ring store,
// search pointer and compare, and the result payload registers.
// ----------------------------------------------------------------------------
module cfws_dp
  import cfws_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  input  dp_ctl_t                  ctl,
  output dp_sts_t                  sts,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic                     out_found
);

  localparam int AW = $clog2(QUEUE_SLOTS);

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] idx);
    slot_inc = (idx == AW'(QUEUE_SLOTS - 1)) ? '0 : idx + AW'(1);
  endfunction

  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] key_r;
  logic [AW-1:0]     head_r, tail_r, pos_r;
  logic              cmp_pend_r;
  logic [AW-1:0]     head_inc, tail_inc, pos_inc;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              hit;
  logic [STAT_W-1:0] status_r;
  logic [DATA_W-1:0] read_r;
  logic              found_r;

  assign head_inc = slot_inc(head_r);
  assign tail_inc = slot_inc(tail_r);
  assign pos_inc  = slot_inc(pos_r);

  // a compare is pending from the first search read of a request until the next load
  assign hit = cmp_pend_r && (rd_data == key_r);

  assign sts.cmd       = cmd_r;
  assign sts.full      = (tail_inc == head_r);
  assign sts.empty     = (head_r == tail_r);
  assign sts.srch_done = hit || (pos_r == tail_r);

  assign rd_addr = ctl.deq_read ? head_inc : pos_inc;

  cfws_ram #(
    .WIDTH(DATA_W),
    .DEPTH(QUEUE_SLOTS)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ctl.enq_write),
    .wr_addr(tail_inc),
    .wr_data(key_r),
    .rd_en  (ctl.deq_read || ctl.srch_step),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= AW'(1);
      tail_r     <= AW'(1);
      cmp_pend_r <= 1'b0;
    end else begin
      if (ctl.deq_read) begin
        head_r <= head_inc;
      end
      if (ctl.enq_write) begin
        tail_r <= tail_inc;
      end
      if (ctl.load) begin
        cmp_pend_r <= 1'b0;
      end else if (ctl.srch_step) begin
        cmp_pend_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      key_r <= in_value;
      pos_r <= head_r;
    end else if (ctl.srch_step) begin
      pos_r <= pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      case (ctl.res_kind)
        RES_FULL: begin
          status_r <= ST_FULL;
          read_r   <= '0;
          found_r  <= 1'b0;
        end
        RES_EMPTY: begin
          status_r <= ST_EMPTY;
          read_r   <= '0;
          found_r  <= 1'b0;
        end
        RES_READ: begin
          status_r <= ST_OK;
          read_r   <= rd_data;
          found_r  <= 1'b0;
        end
        RES_SRCH: begin
          status_r <= ST_OK;
          read_r   <= '0;
          found_r  <= hit;
        end
        default: begin
          status_r <= ST_OK;
          read_r   <= '0;
          found_r  <= 1'b0;
        end
      endcase
    end
  end

  assign out_status     = status_r;
  assign out_read_value = read_r;
  assign out_found      = found_r;

endmodule

// ===== hw/rtl/circular_fifo_with_search.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_search
// Ring-buffer queue of signed 32-bit words with enqueue, dequeue and search.
// ----------------------------------------------------------------------------
// The queue keeps one slot empty and so holds QUEUE_SLOTS-1 words. One request
// is worked on at a time and each gives exactly one result. A search reads the
// occupied slots oldest first, up to and including a match (all of them when
// nothing matches, so at most QUEUE_SLOTS-1), through the single read port of
// the ring store, which is read once a cycle. A finished result sits in the
// output register; the next request is taken as soon as the block is back in
// idle, even while that result is stalled, and waits at its end only if the
// previous one is unread.
module circular_fifo_with_search
  import cfws_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic                     out_found
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  cfws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  cfws_dp #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_command),
    .in_value      (in_value),
    .ctl           (ctl),
    .sts           (sts),
    .out_status    (out_status),
    .out_read_value(out_read_value),
    .out_found     (out_found)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circular FIFO with search: drives enqueue,
// dequeue, search and unused commands with random gaps and output stalls, and
// compares every result against a behavioral ring-queue predictor.
// ----------------------------------------------------------------------------
module tb;
  import cfws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS         = QUEUE_SLOTS_DEF;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam int          RANDOM_ITEMS  = 1050;
  localparam int          DRAIN_CYCLES  = 40;
  localparam longint      LIMIT_CYCLES  = 600_000;

  typedef struct packed {
    stat_t       status;
    logic [31:0] read_value;
    logic        found;
  } queue_result_t;

  // Behavioral ring queue plus the list of results it still owes
  class ring_queue_checker;
    logic [31:0]   ring [SLOTS];
    int            head;
    int            tail;
    queue_result_t due_results [$];
    int unsigned   accepted;
    int unsigned   checked;
    int unsigned   mismatches;

    function new();
      head = 1 % SLOTS;
      tail = 1 % SLOTS;
      foreach (ring[i]) ring[i] = '0;
      accepted   = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function int count();
      return (tail - head + SLOTS) % SLOTS;
    endfunction

    function logic [31:0] held_word(int k);
      return ring[(head + 1 + (k % SLOTS)) % SLOTS];
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_request(logic [1:0] c, logic [31:0] w);
      queue_result_t r;
      int            pos;
      r = '{status: ST_OK, read_value: '0, found: 1'b0};
      case (c)
        CMD_ENQUEUE: begin
          if ((tail + 1) % SLOTS == head) begin
            r.status = ST_FULL;
          end else begin
            tail       = (tail + 1) % SLOTS;
            ring[tail] = w;
          end
        end
        CMD_DEQUEUE: begin
          if (head == tail) begin
            r.status = ST_EMPTY;
          end else begin
            head         = (head + 1) % SLOTS;
            r.read_value = ring[head];
          end
        end
        CMD_SEARCH: begin
          // scan occupied slots, oldest to newest
          pos = head;
          while (pos != tail && !r.found) begin
            pos = (pos + 1) % SLOTS;
            if (ring[pos] == w) r.found = 1'b1;
          end
        end
        default: ;
      endcase
      due_results.push_back(r);
      accepted++;
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] rd, logic hit);
      queue_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d read %h found %0d", st, rd, hit);
        return;
      end
      want = due_results.pop_front();
      if (want.status !== st || want.read_value !== rd || want.found !== hit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected status %0d read %h found %0d, got %0d %h %0d",
                   checked, want.status, want.read_value, want.found, st, rd, hit);
      end
      checked++;
    endfunction
  endclass

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command     = '0;
  logic signed [DATA_W-1:0] in_value       = '0;
  logic                     out_valid;
  logic                     out_stall      = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_read_value;
  logic                     out_found;

  ring_queue_checker sb;
  bit                steady = 1'b0;

  circular_fifo_with_search u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_found      (out_found)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_status, out_read_value, out_found);
      if (in_valid && !in_stall) sb.note_request(in_command, in_value);
    end
  end

  // Call right after a rising edge; returns at the edge that takes the request
  task automatic send_request(input logic [1:0] c, input logic [31:0] w);
    in_valid   <= 1'b1;
    in_command <= c;
    in_value   <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_sender();
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!steady) begin
      if (r >= 90)      gap = $urandom_range(10, 40);
      else if (r >= 50) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    // small values repeat often, so searches meet duplicates
    return $urandom_range(0, 7);
  endfunction

  // bias 0 leans toward filling, 1 toward draining, 2 is balanced
  task automatic random_request(input int bias);
    int          r;
    int          enq_cut;
    int          deq_cut;
    logic [1:0]  c;
    logic [31:0] w;
    r       = $urandom_range(0, 99);
    enq_cut = (bias == 0) ? 55 : (bias == 1) ? 25 : 40;
    deq_cut = (bias == 0) ? 75 : (bias == 1) ? 72 : 76;
    if (r < enq_cut)      c = CMD_ENQUEUE;
    else if (r < deq_cut) c = CMD_DEQUEUE;
    else if (r < 97)      c = CMD_SEARCH;
    else                  c = CMD_UNUSED;
    w = random_word();
    if (c == CMD_SEARCH && sb.count() > 0 && $urandom_range(0, 2) != 0)
      w = sb.held_word($urandom_range(0, sb.count() - 1));
    send_request(c, w);
    idle_sender();
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: mostly short stalls, some long, one long hold-off to back up the input
  initial begin : receiver
    int  stall_left;
    int  r;
    bit  hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sb.accepted >= 400) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (steady || r < 55) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(7, 29);
        out_stall <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] w;
    int          n;
    int          bias;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: dequeue and search, then the unused code
    send_request(CMD_DEQUEUE, $urandom);
    idle_sender();
    send_request(CMD_SEARCH, 32'h0000_0000);
    idle_sender();
    send_request(CMD_UNUSED, 32'hFFFF_FFFF);
    idle_sender();
    // fill to capacity with the corner words first
    for (n = 0; n < SLOTS - 1; n++) begin
      case (n)
        0:       w = 32'h8000_0000;
        1:       w = 32'h7FFF_FFFF;
        2:       w = 32'h0000_0000;
        3:       w = 32'hFFFF_FFFF;
        4:       w = 32'hAAAA_AAAA;
        5:       w = 32'h5555_5555;
        default: w = $urandom;
      endcase
      send_request(CMD_ENQUEUE, w);
      idle_sender();
    end
    send_request(CMD_ENQUEUE, 32'h1234_5678);
    idle_sender();
    send_request(CMD_SEARCH, 32'h8000_0000);
    idle_sender();
    send_request(CMD_SEARCH, w);
    idle_sender();
    send_request(CMD_SEARCH, 32'h0000_0001);
    idle_sender();
    for (n = 0; n < 2; n++) begin
      send_request(CMD_DEQUEUE, $urandom);
      idle_sender();
    end
    // refill the two slots freed by the dequeues
    for (n = 0; n < 2; n++) begin
      send_request(CMD_ENQUEUE, $urandom);
      idle_sender();
    end

    bias = 2;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) bias = $urandom_range(0, 2);
      steady = (n >= 200 && n < 300);
      if (n == 700) wait_all_results();
      random_request(bias);
    end
    steady = 1'b0;

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 20);
    $display("tb NOT OK");
    $finish;
  end

endmodule
